@@ rtl/rlex_pkg.sv @@
package rlex_pkg;

  // Frame geometry: 256 x 64 pixels, one bit each
  localparam int FRAME_BYTES  = 256 * 64 / 8;
  localparam int BUFFER_BYTES = FRAME_BYTES;

  localparam int RUN_W   = 8;
  localparam int FILL_W  = 3;
  localparam int POS_W   = 12;
  localparam int IDX_W   = 11;
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(7);
  localparam logic [POS_W-1:0]  POS_MAX   = {POS_W{1'b1}};

  typedef struct packed {
    logic [RUN_W-1:0] run_length;
    logic             final_run;
  } rlex_in_t;

  typedef struct packed {
    logic [7:0]       packed_byte;
    logic [IDX_W-1:0] byte_index;
    logic             last_of_run;
    logic             frame_end;
    logic             overflow;
  } rlex_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } rlex_state_e;

endpackage

@@ rtl/rlex_packer.sv @@
module rlex_packer
  import rlex_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rlex_in_t  in_data_i,
  output logic      emit_valid_o,
  input  logic      emit_ready_i,
  output rlex_out_t emit_data_o
);

  rlex_state_e       state_q, state_d;
  logic [7:0]        pend_q, pend_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              color_q, color_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [RUN_W-1:0]  remain_q, remain_d;
  logic              final_q, final_d;

  logic [RUN_W-1:0]  remain_dec;
  logic [POS_W-1:0]  pos_inc;
  logic              shift_bit;
  logic              over;

  // Shared helpers for the serial datapath
  assign remain_dec = remain_q - RUN_W'(1);
  assign pos_inc    = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
  assign shift_bit  = (state_q == ST_RUN) ? color_q : 1'b0;
  assign over       = ({1'b0, pos_q} >= (POS_W+1)'(BUFFER_BYTES));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (remain_q == '0) begin
          state_d = (final_q && fill_q != '0) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (fill_q == FILL_LAST && emit_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates and outputs: one pixel shifted in per cycle while running, unless a completed byte is stalled
  always_comb begin
    pend_d   = pend_q;
    fill_d   = fill_q;
    color_d  = color_q;
    pos_d    = pos_q;
    remain_d = remain_q;
    final_d  = final_q;
    in_stall_o   = (state_q != ST_IDLE);
    emit_valid_o = 1'b0;
    emit_data_o.packed_byte = {pend_q[6:0], shift_bit};
    emit_data_o.byte_index  = over ? '0 : pos_q[IDX_W-1:0];
    emit_data_o.overflow    = over;
    emit_data_o.last_of_run = 1'b0;
    emit_data_o.frame_end   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // Capture the transaction
        if (in_valid_i) begin
          remain_d = in_data_i.run_length;
          final_d  = in_data_i.final_run;
        end
      end
      ST_RUN: begin
        if (remain_q != '0) begin
          if (fill_q == FILL_LAST) begin
            // Byte completes: last unless more bytes or a flush follow
            emit_valid_o = 1'b1;
            emit_data_o.last_of_run = (remain_dec[RUN_W-1:3] == '0) &&
                                      !(final_q && remain_dec != '0);
            emit_data_o.frame_end   = final_q && (remain_dec == '0);
            if (emit_ready_i) begin
              pend_d   = '0;
              fill_d   = '0;
              pos_d    = pos_inc;
              remain_d = remain_dec;
            end
          end else begin
            pend_d   = {pend_q[6:0], shift_bit};
            fill_d   = fill_q + FILL_W'(1);
            remain_d = remain_dec;
          end
        end else if (final_q) begin
          // End of frame: return colour, and position if nothing to flush
          color_d = 1'b0;
          if (fill_q == '0) pos_d = '0;
        end else begin
          color_d = ~color_q;
        end
      end
      ST_FLUSH: begin
        // Pad with zeros until the byte is full, then emit it
        if (fill_q == FILL_LAST) begin
          emit_valid_o = 1'b1;
          emit_data_o.last_of_run = 1'b1;
          emit_data_o.frame_end   = 1'b1;
          if (emit_ready_i) begin
            pend_d = '0;
            fill_d = '0;
            pos_d  = '0;
          end
        end else begin
          pend_d = {pend_q[6:0], 1'b0};
          fill_d = fill_q + FILL_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_q   <= '0;
      fill_q   <= '0;
      color_q  <= 1'b0;
      pos_q    <= '0;
      remain_q <= '0;
      final_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      fill_q   <= fill_d;
      color_q  <= color_d;
      pos_q    <= pos_d;
      remain_q <= remain_d;
      final_q  <= final_d;
    end
  end

endmodule

@@ rtl/rlex_out_stage.sv @@
module rlex_out_stage
  import rlex_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      emit_valid_i,
  output logic      emit_ready_o,
  input  rlex_out_t emit_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rlex_out_t out_data_o
);

  logic      valid_q, valid_d;
  rlex_out_t data_q, data_d;
  logic      take;

  // Load when empty or when the held transaction leaves
  assign take         = !valid_q || !out_stall_i;
  assign emit_ready_o = take;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (take) begin
      valid_d = emit_valid_i;
      if (emit_valid_i) data_d = emit_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ rtl/bilevel_run_length_expander_core.sv @@
// A run that starts on a byte boundary shows its first byte once its eighth pixel is packed and registered.
// A new run is accepted only after the previous one ends, including padding of a final partial byte;
// pixels are shifted into the packing register one per cycle while the output takes completed bytes.
// Output stalls freeze the packer only when it has a byte to hand over.
// Reset (asynchronous, active low) clears colour to black, position and packing state.
module bilevel_run_length_expander_core
  import rlex_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rlex_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rlex_out_t out_data_o
);

  logic      emit_valid;
  logic      emit_ready;
  rlex_out_t emit_data;

  // Serial pixel packer
  rlex_packer u_packer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .emit_valid_o (emit_valid),
    .emit_ready_i (emit_ready),
    .emit_data_o  (emit_data)
  );

  // Output register
  rlex_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_valid_i (emit_valid),
    .emit_ready_o (emit_ready),
    .emit_data_i  (emit_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

@@ rtl/rlex_checker.sv @@
module rlex_checker
  import rlex_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input rlex_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input rlex_out_t out_data_o
);

  // Stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // Overflow bytes carry index zero
  a_over_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> out_data_o.byte_index == '0)
    else $error("overflow byte with nonzero index");

  // End of frame is always the last byte of its run
  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |-> out_data_o.last_of_run)
    else $error("frame_end without last_of_run");

  // One run at a time: stall follows every accepted transaction
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after acceptance");

endmodule

bind bilevel_run_length_expander_core rlex_checker u_rlex_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
